@@ sv/hcb_pkg.sv @@
`timescale 1ns / 1ps
package hcb_pkg;

  localparam int SYM_W = 8;
  localparam int WT_IN_W = 16;
  localparam int CODE_W = 15;
  localparam int CLEN_W = 4;
  localparam int LEN_W = 5;

  typedef enum logic [14:0] {
    S_LOAD   = 15'b000000000000001,
    S_INIT   = 15'b000000000000010,
    S_RDL    = 15'b000000000000100,
    S_RDW    = 15'b000000000001000,
    S_CMP    = 15'b000000000010000,
    S_MRG1   = 15'b000000000100000,
    S_MRG2   = 15'b000000001000000,
    S_RDROOT = 15'b000000010000000,
    S_ROOT   = 15'b000000100000000,
    S_POP    = 15'b000001000000000,
    S_NODE   = 15'b000010000000000,
    S_LEAF   = 15'b000100000000000,
    S_PUSH1  = 15'b001000000000000,
    S_PUSH2  = 15'b010000000000000,
    S_WAIT   = 15'b100000000000000
  } state_t;

endpackage

@@ sv/huffman_code_builder.sv @@
`timescale 1ns / 1ps
// sequence: loading accepts one item per cycle; after the final item, setup fills the live
// list, each merge round scans every live node through the compare state and the single
// weight read port, then the root is fetched, the tree is walked with a node stack (a leaf
// code is registered in the leaf state and held until taken) and the batch closes
// throughput: one batch at a time, input stalled from the final item until the last code
// reset: synchronous active-high rst clears the sequencer, symbol count, overflow flag and output valid
module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic [hcb_pkg::SYM_W-1:0] symbol,
  input  logic [hcb_pkg::WT_IN_W-1:0] weight,
  input  logic final_entry,
  output logic out_valid,
  input  logic out_stall,
  output logic [hcb_pkg::SYM_W-1:0] out_symbol,
  output logic [hcb_pkg::CODE_W-1:0] code_bits,
  output logic [hcb_pkg::CLEN_W-1:0] code_length,
  output logic overflowed,
  output logic last_code
);
  import hcb_pkg::*;

  localparam int LW = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int NW = $clog2(2 * MAX_SYMBOLS);
  localparam int NODES = 2 * MAX_SYMBOLS;
  localparam int IW = (WEIGHT_BITS < WT_IN_W) ? WEIGHT_BITS : WT_IN_W;
  localparam int WW = IW + CW;
  localparam int SPW = $clog2(NODES + 1);
  localparam int STW = NW + CODE_W + LEN_W;

  state_t state;
  logic [CW-1:0] symbol_count, idx, live;
  logic overflow_seen;
  logic [NW-1:0] next_node, cur_node, node_a, node_b;
  logic [LW-1:0] ia, ib;
  logic [WW-1:0] wa, wb;
  logic bval;
  logic [SPW-1:0] sp;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0] len;

  // memories
  logic [SYM_W-1:0] leaf_mem [MAX_SYMBOLS];
  logic [WW-1:0] wt_mem [NODES];
  logic [2*NW-1:0] child_mem [NODES];
  logic [NW-1:0] live_mem [MAX_SYMBOLS];
  logic [STW-1:0] stack_mem [NODES];

  logic leaf_we, leaf_re;
  logic [LW-1:0] leaf_waddr, leaf_raddr;
  logic [SYM_W-1:0] leaf_q;
  logic wt_we, wt_re;
  logic [NW-1:0] wt_waddr, wt_raddr;
  logic [WW-1:0] wt_wdata, wt_q;
  logic ch_we, ch_re;
  logic [NW-1:0] ch_raddr;
  logic [2*NW-1:0] ch_q;
  logic lv_we, lv_re;
  logic [LW-1:0] lv_waddr, lv_raddr;
  logic [NW-1:0] lv_wdata, lv_q;
  logic st_we, st_re;
  logic [NW-1:0] st_waddr, st_raddr;
  logic [STW-1:0] st_wdata, st_q;

  logic in_acc, has_room;
  logic [CW-1:0] tail;
  logic is_leaf;

  assign stall = (state != S_LOAD);
  assign in_acc = valid && !stall;
  assign has_room = (symbol_count < CW'(MAX_SYMBOLS));
  assign tail = live - CW'(1);
  assign is_leaf = ({1'b0, st_q[STW-1 -: NW]} < {1'b0, NW'(symbol_count)});

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= symbol;
    if (leaf_re) leaf_q <= leaf_mem[leaf_raddr];
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    if (wt_re) wt_q <= wt_mem[wt_raddr];
    if (ch_we) child_mem[next_node] <= {node_a, node_b};
    if (ch_re) ch_q <= child_mem[ch_raddr];
    if (lv_we) live_mem[lv_waddr] <= lv_wdata;
    if (lv_re) lv_q <= live_mem[lv_raddr];
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    if (st_re) st_q <= stack_mem[st_raddr];
  end

  always_comb begin
    leaf_we = 1'b0; leaf_re = 1'b0;
    leaf_waddr = symbol_count[LW-1:0]; leaf_raddr = st_q[STW-NW +: LW];
    wt_we = 1'b0; wt_re = 1'b0;
    wt_waddr = NW'(symbol_count); wt_raddr = lv_q;
    wt_wdata = WW'(weight[IW-1:0]);
    ch_we = 1'b0; ch_re = 1'b0; ch_raddr = st_q[STW-1 -: NW];
    lv_we = 1'b0; lv_re = 1'b0;
    lv_waddr = idx[LW-1:0]; lv_raddr = idx[LW-1:0]; lv_wdata = NW'(idx);
    st_we = 1'b0; st_re = 1'b0;
    st_waddr = NW'(sp); st_raddr = NW'(sp - SPW'(1));
    st_wdata = {lv_q, {CODE_W{1'b0}}, {LEN_W{1'b0}}};
    unique case (state)
      S_LOAD: begin
        leaf_we = in_acc && has_room;
        wt_we = in_acc && has_room;
      end
      S_INIT: lv_we = 1'b1;
      S_RDL: lv_re = 1'b1;
      S_RDW: wt_re = 1'b1;
      S_CMP: ;
      S_MRG1: begin
        ch_we = 1'b1;
        wt_we = 1'b1;
        wt_waddr = next_node;
        wt_wdata = wa + wb;
        lv_we = 1'b1;
        lv_waddr = (ia < ib) ? ia : ib;
        lv_wdata = next_node;
        lv_re = 1'b1;
        lv_raddr = tail[LW-1:0];
      end
      S_MRG2: begin
        lv_we = 1'b1;
        lv_waddr = (ia < ib) ? ib : ia;
        lv_wdata = lv_q;
      end
      S_RDROOT: begin
        lv_re = 1'b1;
        lv_raddr = '0;
      end
      S_ROOT: begin
        st_we = 1'b1;
        st_waddr = '0;
      end
      S_POP: st_re = (sp != '0);
      S_NODE: begin
        leaf_re = is_leaf;
        ch_re = !is_leaf;
      end
      S_LEAF: ;
      S_PUSH1: begin
        st_we = 1'b1;
        st_wdata = {ch_q[NW-1:0], code[CODE_W-2:0], 1'b1, len + LEN_W'(1)};
      end
      S_PUSH2: begin
        st_we = 1'b1;
        st_waddr = NW'(sp + SPW'(1));
        st_wdata = {ch_q[2*NW-1 -: NW], code[CODE_W-2:0], 1'b0, len + LEN_W'(1)};
      end
      S_WAIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      symbol_count <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (has_room) symbol_count <= symbol_count + CW'(1);
            else overflow_seen <= 1'b1;
            if (final_entry) begin
              idx <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          idx <= idx + CW'(1);
          if (idx + CW'(1) == symbol_count) begin
            live <= symbol_count;
            next_node <= NW'(symbol_count);
            idx <= '0;
            bval <= 1'b0;
            state <= (symbol_count == CW'(1)) ? S_RDROOT : S_RDL;
          end
        end
        S_RDL: state <= S_RDW;
        S_RDW: begin
          cur_node <= lv_q;
          state <= S_CMP;
        end
        S_CMP: begin
          if (idx == '0 || wt_q < wa) begin
            if (idx != '0) begin
              wb <= wa; node_b <= node_a; ib <= ia; bval <= 1'b1;
            end
            wa <= wt_q; node_a <= cur_node; ia <= idx[LW-1:0];
          end else if (!bval || wt_q < wb) begin
            wb <= wt_q; node_b <= cur_node; ib <= idx[LW-1:0]; bval <= 1'b1;
          end
          idx <= idx + CW'(1);
          state <= (idx + CW'(1) == live) ? S_MRG1 : S_RDL;
        end
        S_MRG1: state <= S_MRG2;
        S_MRG2: begin
          next_node <= next_node + NW'(1);
          live <= tail;
          idx <= '0;
          bval <= 1'b0;
          state <= (tail == CW'(1)) ? S_RDROOT : S_RDL;
        end
        S_RDROOT: state <= S_ROOT;
        S_ROOT: begin
          sp <= SPW'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            symbol_count <= '0;
            overflow_seen <= 1'b0;
            state <= S_LOAD;
          end else begin
            sp <= sp - SPW'(1);
            state <= S_NODE;
          end
        end
        S_NODE: begin
          code <= st_q[LEN_W +: CODE_W];
          len <= st_q[LEN_W-1:0];
          state <= is_leaf ? S_LEAF : S_PUSH1;
        end
        S_LEAF: begin
          out_symbol <= leaf_q;
          code_bits <= code;
          code_length <= len[CLEN_W-1:0];
          overflowed <= overflow_seen;
          last_code <= (sp == '0);
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_PUSH1: state <= S_PUSH2;
        S_PUSH2: begin
          sp <= sp + SPW'(2);
          state <= S_POP;
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_POP;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import hcb_pkg::*;

  localparam int NSYM = 16;
  localparam int NSLOT = 2 * NSYM;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [CODE_W-1:0] bits;
    logic [CLEN_W-1:0] len;
    logic ovf;
    logic last;
  } code_t;

  class code_board;
    code_t pending[$];
    int errors;
    int unsigned cnt;
    logic [SYM_W-1:0] leaf_sym[NSYM];
    logic [19:0] wt[NSLOT];
    int zc[NSLOT];
    int oc[NSLOT];
    bit ovf;

    function new();
      errors = 0;
      cnt = 0;
      ovf = 0;
    endfunction

    function void note_item(logic [SYM_W-1:0] s, logic [WT_IN_W-1:0] w, logic fin);
      int lst[NSYM];
      int live, nxt, a, b, lo, hi, sp, nd, root;
      int stk_nd[NSLOT];
      logic [31:0] stk_code[NSLOT];
      int stk_len[NSLOT];
      code_t r;
      int first;
      if (cnt < NSYM) begin
        leaf_sym[cnt] = s;
        wt[cnt] = 20'(w);
        cnt++;
      end else ovf = 1;
      if (!fin) return;
      live = cnt;
      nxt = cnt;
      for (int i = 0; i < cnt; i++) lst[i] = i;
      while (live > 1) begin
        a = 0;
        b = 1;
        if (wt[lst[1]] < wt[lst[0]]) begin
          a = 1;
          b = 0;
        end
        for (int i = 2; i < live; i++) begin
          if (wt[lst[i]] < wt[lst[a]]) begin
            b = a;
            a = i;
          end else if (wt[lst[i]] < wt[lst[b]]) b = i;
        end
        zc[nxt] = lst[a];
        oc[nxt] = lst[b];
        wt[nxt] = wt[lst[a]] + wt[lst[b]];
        lo = a < b ? a : b;
        hi = a < b ? b : a;
        lst[lo] = nxt;
        lst[hi] = lst[live-1];
        nxt++;
        live--;
      end
      root = lst[0];
      stk_nd[0] = root;
      stk_code[0] = 0;
      stk_len[0] = 0;
      sp = 1;
      first = pending.size();
      while (sp > 0) begin
        sp--;
        nd = stk_nd[sp];
        if (nd < cnt) begin
          r.sym = leaf_sym[nd];
          r.bits = stk_code[sp][CODE_W-1:0];
          r.len = stk_len[sp][CLEN_W-1:0];
          r.ovf = ovf;
          r.last = 0;
          pending.push_back(r);
        end else if (sp + 2 <= NSLOT) begin
          stk_nd[sp+1] = zc[nd];
          stk_code[sp+1] = stk_code[sp] << 1;
          stk_len[sp+1] = stk_len[sp] + 1;
          stk_nd[sp] = oc[nd];
          stk_code[sp] = (stk_code[sp] << 1) | 1;
          stk_len[sp] = stk_len[sp] + 1;
          sp += 2;
        end
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1;
      cnt = 0;
      ovf = 0;
    endfunction

    function void check_code(code_t act);
      code_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected code sym=%h bits=%h len=%0d", $time, act.sym, act.bits,
                 act.len);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e !== act) begin
        $display("%0t: mismatch expected sym=%h bits=%h len=%0d ovf=%b last=%b", $time,
                 e.sym, e.bits, e.len, e.ovf, e.last);
        $display("%0t:          actual   sym=%h bits=%h len=%0d ovf=%b last=%b", $time,
                 act.sym, act.bits, act.len, act.ovf, act.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic valid = 0;
  logic stall;
  logic [SYM_W-1:0] symbol = 0;
  logic [WT_IN_W-1:0] weight = 0;
  logic final_entry = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [SYM_W-1:0] out_symbol;
  logic [CODE_W-1:0] code_bits;
  logic [CLEN_W-1:0] code_length;
  logic overflowed;
  logic last_code;

  code_board board = new();
  bit quiet = 0;
  bit hold_off = 0;
  bit running = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  huffman_code_builder u_dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .symbol(symbol),
    .weight(weight), .final_entry(final_entry), .out_valid(out_valid),
    .out_stall(out_stall), .out_symbol(out_symbol), .code_bits(code_bits),
    .code_length(code_length), .overflowed(overflowed), .last_code(last_code)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_code('{out_symbol, code_bits, code_length, overflowed, last_code});
    if (!rst && ((valid && !stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (running && idle_cycles > WATCH_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end else out_stall <= 0;
    end
  end

  task automatic send_item(logic [SYM_W-1:0] s, logic [WT_IN_W-1:0] w, logic fin);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    valid <= 1;
    symbol <= s;
    weight <= w;
    final_entry <= fin;
    @(posedge clk);
    while (stall) @(posedge clk);
    board.note_item(s, w, fin);
  endtask

  task automatic send_batch(int n, int wmode);
    logic [WT_IN_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      case (wmode)
        0: w = WT_IN_W'($urandom);
        1: w = WT_IN_W'($urandom_range(0, 7));
        2: w = 16'hffff;
        3: w = (i < 16) ? (16'd1 << i) : 16'd1;
        default: w = 16'd5;
      endcase
      send_item(SYM_W'($urandom), w, i == n - 1);
    end
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst <= 0;
    running = 1;
    send_item(8'h00, 16'h0000, 1);
    send_item(8'hff, 16'hffff, 1);
    send_batch(2, 2);
    send_batch(16, 3);
    send_batch(4, 4);
    send_item(8'h55, 16'h0000, 0);
    send_item(8'haa, 16'hffff, 1);
    // long stall on output while batches are offered
    hold_off = 1;
    send_batch(3, 0);
    send_batch(5, 0);
    send_batch(20, 1);
    while (board.pending.size() < 1000 && n < 19) begin
      n++;
      case ($urandom_range(0, 5))
        0: send_batch($urandom_range(1, 3), 0);
        1: send_batch($urandom_range(17, 19), $urandom_range(0, 1));
        2: send_batch(16, $urandom_range(0, 3));
        default: send_batch($urandom_range(2, 12), $urandom_range(0, 4));
      endcase
      if (n == 14) quiet = 1;
    end
    valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
